// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcrm_pkg.sv =====
package lcrm_pkg;

  localparam int SPAN      = 5;
  localparam int WIN       = 2 * SPAN + 2;
  localparam int AGE_W     = $clog2(WIN);
  localparam int NUM_W     = $clog2(WIN + 1);
  localparam int COORD_W   = 19;
  localparam int CNT_W     = 17;
  localparam int CURV_W    = 47;
  localparam int D_W       = COORD_W + $clog2(4 * SPAN);
  localparam int OPV_W     = 25;
  localparam int MAG_W     = 24;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int ACC_W     = 94;
  localparam int CHUNK     = 19;
  localparam int NORM_W    = 38;
  localparam int GAP_W     = 40;
  localparam int DOT_W     = 39;
  localparam int LIM_W     = 54;
  localparam int PP_W      = 76;
  localparam int PCOS_W    = 93;
  localparam int NSTEP     = 32;
  localparam int STEP_W    = $clog2(NSTEP);
  localparam int LAST_STEP = NSTEP - 1;
  localparam int DRAIN     = 3;
  localparam int DRAIN_W   = 2;
  localparam int IDX_W     = 2;
  localparam int CFG_W     = 32;
  localparam int GAPL_W    = 32;
  localparam int COS_W     = 17;
  localparam int PAR_W     = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [GAPL_W-1:0] GAP_RST     = 32'd100000;
  localparam logic [COS_W-1:0]  COS_RST     = 17'd64883;
  localparam logic [PAR_W-1:0]  PAR_RST     = 16'd13;

  typedef enum logic [IDX_W-1:0] {
    REG_GAP_SQ    = 2'd0,
    REG_COS_SQ    = 2'd1,
    REG_PAR_RATIO = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    SRC_PIX, SRC_PIY, SRC_PIZ,
    SRC_PNX, SRC_PNY, SRC_PNZ,
    SRC_GX, SRC_GY, SRC_GZ,
    SRC_HX, SRC_HY, SRC_HZ,
    SRC_DX, SRC_DY, SRC_DZ,
    SRC_N1LO, SRC_N1HI, SRC_N2LO, SRC_N2HI,
    SRC_DOTLO, SRC_DOTHI,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3,
    SRC_COS, SRC_PAR
  } src_t;

  typedef enum logic [1:0] {SH_0, SH_19, SH_38, SH_57} sh_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_N1, DST_N2, DST_GAP, DST_GAP2, DST_DOT,
    DST_CURV, DST_LIM, DST_PROD, DST_DSQ, DST_PCOS
  } dst_t;

  typedef struct packed {
    src_t       a;
    src_t       b;
    sh_t        sh;
    logic       first;
    dst_t       dst;
  } uop_t;

  typedef struct packed {
    logic              mac_valid;
    logic [STEP_W-1:0] mac_step;
    logic              decide;
    logic              emit_active;
    logic [AGE_W-1:0]  emit_age;
    logic              emit_last;
  } cmd_t;

  typedef struct packed {
    logic             end_item;
    logic             cnt_ge_win;
    logic [NUM_W-1:0] flush_n;
    logic             out_space;
  } stat_t;

  function automatic uop_t mk(input src_t a, input src_t b, input sh_t sh,
                              input logic first, input dst_t dst);
    uop_t u;
    u.a     = a;
    u.b     = b;
    u.sh    = sh;
    u.first = first;
    u.dst   = dst;
    return u;
  endfunction

  // multiply-accumulate program for one point
  function automatic uop_t uop_at(input logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      5'd0:  u = mk(SRC_PIX, SRC_PIX, SH_0, 1'b1, DST_NONE);
      5'd1:  u = mk(SRC_PIY, SRC_PIY, SH_0, 1'b0, DST_NONE);
      5'd2:  u = mk(SRC_PIZ, SRC_PIZ, SH_0, 1'b0, DST_N1);
      5'd3:  u = mk(SRC_PNX, SRC_PNX, SH_0, 1'b1, DST_NONE);
      5'd4:  u = mk(SRC_PNY, SRC_PNY, SH_0, 1'b0, DST_NONE);
      5'd5:  u = mk(SRC_PNZ, SRC_PNZ, SH_0, 1'b0, DST_N2);
      5'd6:  u = mk(SRC_GX, SRC_GX, SH_0, 1'b1, DST_NONE);
      5'd7:  u = mk(SRC_GY, SRC_GY, SH_0, 1'b0, DST_NONE);
      5'd8:  u = mk(SRC_GZ, SRC_GZ, SH_0, 1'b0, DST_GAP);
      5'd9:  u = mk(SRC_HX, SRC_HX, SH_0, 1'b1, DST_NONE);
      5'd10: u = mk(SRC_HY, SRC_HY, SH_0, 1'b0, DST_NONE);
      5'd11: u = mk(SRC_HZ, SRC_HZ, SH_0, 1'b0, DST_GAP2);
      5'd12: u = mk(SRC_PIX, SRC_PNX, SH_0, 1'b1, DST_NONE);
      5'd13: u = mk(SRC_PIY, SRC_PNY, SH_0, 1'b0, DST_NONE);
      5'd14: u = mk(SRC_PIZ, SRC_PNZ, SH_0, 1'b0, DST_DOT);
      5'd15: u = mk(SRC_DX, SRC_DX, SH_0, 1'b1, DST_NONE);
      5'd16: u = mk(SRC_DY, SRC_DY, SH_0, 1'b0, DST_NONE);
      5'd17: u = mk(SRC_DZ, SRC_DZ, SH_0, 1'b0, DST_CURV);
      5'd18: u = mk(SRC_N1LO, SRC_PAR, SH_0, 1'b1, DST_NONE);
      5'd19: u = mk(SRC_N1HI, SRC_PAR, SH_19, 1'b0, DST_LIM);
      5'd20: u = mk(SRC_N1LO, SRC_N2LO, SH_0, 1'b1, DST_NONE);
      5'd21: u = mk(SRC_N1LO, SRC_N2HI, SH_19, 1'b0, DST_NONE);
      5'd22: u = mk(SRC_N1HI, SRC_N2LO, SH_19, 1'b0, DST_NONE);
      5'd23: u = mk(SRC_N1HI, SRC_N2HI, SH_38, 1'b0, DST_PROD);
      5'd24: u = mk(SRC_DOTLO, SRC_DOTLO, SH_0, 1'b1, DST_NONE);
      5'd25: u = mk(SRC_DOTLO, SRC_DOTHI, SH_19, 1'b0, DST_NONE);
      5'd26: u = mk(SRC_DOTHI, SRC_DOTLO, SH_19, 1'b0, DST_NONE);
      5'd27: u = mk(SRC_DOTHI, SRC_DOTHI, SH_38, 1'b0, DST_DSQ);
      5'd28: u = mk(SRC_P0, SRC_COS, SH_0, 1'b1, DST_NONE);
      5'd29: u = mk(SRC_P1, SRC_COS, SH_19, 1'b0, DST_NONE);
      5'd30: u = mk(SRC_P2, SRC_COS, SH_38, 1'b0, DST_NONE);
      5'd31: u = mk(SRC_P3, SRC_COS, SH_57, 1'b0, DST_PCOS);
      default: u = mk(SRC_PIX, SRC_PIX, SH_0, 1'b1, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

// ===== sv/lcrm_chan_if.sv =====
interface lcrm_point_if import lcrm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_mm;
  logic signed [COORD_W-1:0] z_mm;
  logic                      end_of_cloud;

  modport source (output valid, x_mm, y_mm, z_mm, end_of_cloud, input ready);
  modport sink (input valid, x_mm, y_mm, z_mm, end_of_cloud, output ready);
endinterface

interface lcrm_result_if import lcrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CURV_W-1:0] curvature;
  logic              curvature_valid;
  logic              excluded;
  logic              last_result;

  modport source (output valid, curvature, curvature_valid, excluded, last_result,
                  input ready);
  modport sink (input valid, curvature, curvature_valid, excluded, last_result,
                output ready);
endinterface

interface lcrm_cfg_if import lcrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/lcrm_ctrl.sv =====
module lcrm_ctrl import lcrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {ST_IDLE, ST_CALC, ST_WAIT, ST_DECIDE, ST_EMIT} state_t;

  state_t             state;
  logic [DRAIN_W-1:0] wcnt;
  logic               flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
      cmd      <= '0;
      wcnt     <= '0;
      flush    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state         <= ST_CALC;
            in_ready      <= 1'b0;
            cmd.mac_valid <= 1'b1;
            cmd.mac_step  <= '0;
          end
        end
        ST_CALC: begin
          if (cmd.mac_step == STEP_W'(LAST_STEP)) begin
            cmd.mac_valid <= 1'b0;
            state         <= ST_WAIT;
            wcnt          <= '0;
          end else begin
            cmd.mac_step <= cmd.mac_step + 1'b1;
          end
        end
        // let the last products retire through the MAC pipe
        ST_WAIT: begin
          if (wcnt == DRAIN_W'(DRAIN - 1)) begin
            state      <= ST_DECIDE;
            cmd.decide <= 1'b1;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_DECIDE: begin
          cmd.decide <= 1'b0;
          if (stat.end_item) begin
            state           <= ST_EMIT;
            flush           <= 1'b1;
            cmd.emit_active <= 1'b1;
            cmd.emit_age    <= AGE_W'(stat.flush_n - 1'b1);
            cmd.emit_last   <= (stat.flush_n == NUM_W'(1));
          end else if (stat.cnt_ge_win) begin
            state           <= ST_EMIT;
            flush           <= 1'b0;
            cmd.emit_active <= 1'b1;
            cmd.emit_age    <= AGE_W'(WIN - 1);
            cmd.emit_last   <= 1'b0;
          end else begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (stat.out_space) begin
            if (!flush || cmd.emit_last) begin
              cmd.emit_active <= 1'b0;
              cmd.emit_last   <= 1'b0;
              state           <= ST_IDLE;
              in_ready        <= 1'b1;
            end else begin
              cmd.emit_age  <= cmd.emit_age - 1'b1;
              cmd.emit_last <= (cmd.emit_age == AGE_W'(1));
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/lcrm_dp.sv =====
module lcrm_dp import lcrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  cmd_t                 cmd,
  output stat_t                stat,
  lcrm_point_if.sink           points,
  lcrm_cfg_if.sink             cfg,
  lcrm_result_if.source        results
);

  // configuration
  logic [GAPL_W-1:0] gap_lim;
  logic [COS_W-1:0]  cos_lim;
  logic [PAR_W-1:0]  par_ratio;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_lim   <= GAP_RST;
      cos_lim   <= COS_RST;
      par_ratio <= PAR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAP_SQ:    gap_lim   <= cfg.data[GAPL_W-1:0];
        REG_COS_SQ:    cos_lim   <= cfg.data[COS_W-1:0];
        REG_PAR_RATIO: par_ratio <= cfg.data[PAR_W-1:0];
        default:       ;
      endcase
    end
  end

  // point window, age 0 is the newest point
  logic signed [COORD_W-1:0] win [WIN][3];
  logic [CURV_W-1:0]         cdel [WIN];
  logic [WIN-1:0]            marks;
  logic [WIN-1:0]            mark_set;
  logic [CNT_W-1:0]          cnt;
  logic                      end_item;

  logic signed [COORD_W:0]   gdiff [3];
  logic signed [COORD_W:0]   hdiff [3];
  logic signed [D_W-1:0]     dcur  [3];
  logic signed [D_W-1:0]     dreg  [3];

  // product results
  logic [NORM_W-1:0]       n1, n2;
  logic [GAP_W-1:0]        gap, gap2;
  logic signed [DOT_W-1:0] dot;
  logic [CURV_W-1:0]       curv;
  logic [LIM_W-1:0]        lim;
  logic [PP_W-1:0]         pp;
  logic [PP_W-1:0]         dsq;
  logic [PCOS_W-1:0]       pcos;

  logic load;
  logic clear;
  logic out_space;
  logic occl, par, n1_gt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gdiff[k] = (COORD_W+1)'(win[SPAN+1][k]) - (COORD_W+1)'(win[SPAN][k]);
      hdiff[k] = (COORD_W+1)'(win[SPAN+1][k]) - (COORD_W+1)'(win[SPAN+2][k]);
    end
  end

  // neighbour sum minus 2*SPAN times the center point
  always_comb begin
    logic signed [D_W-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = '0;
      for (int a = 0; a <= 2 * SPAN; a++) begin
        if (a != SPAN) begin
          s = s + D_W'(win[a][k]);
        end
      end
      dcur[k] = s - D_W'(2 * SPAN) * D_W'(win[SPAN][k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dreg[k] <= dcur[k];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int a = WIN - 1; a > 0; a--) begin
        win[a]  <= win[a-1];
        cdel[a] <= cdel[a-1];
      end
      win[0][0] <= points.x_mm;
      win[0][1] <= points.y_mm;
      win[0][2] <= points.z_mm;
      cdel[0]   <= '0;
    end else if (cmd.decide && cnt >= CNT_W'(2 * SPAN + 1)) begin
      cdel[SPAN] <= curv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt      <= '0;
      marks    <= '0;
      end_item <= 1'b0;
    end else if (in_fire) begin
      marks    <= {marks[WIN-2:0], 1'b0};
      end_item <= points.end_of_cloud;
      if (cnt != CNT_MAX) begin
        cnt <= cnt + 1'b1;
      end
    end else if (cmd.decide && cnt >= CNT_W'(WIN)) begin
      marks <= marks | mark_set;
    end
  end

  // operand select
  function automatic logic signed [OPV_W-1:0] src_val(input src_t s);
    logic signed [OPV_W-1:0] v;
    case (s)
      SRC_PIX:   v = OPV_W'(win[SPAN+1][0]);
      SRC_PIY:   v = OPV_W'(win[SPAN+1][1]);
      SRC_PIZ:   v = OPV_W'(win[SPAN+1][2]);
      SRC_PNX:   v = OPV_W'(win[SPAN][0]);
      SRC_PNY:   v = OPV_W'(win[SPAN][1]);
      SRC_PNZ:   v = OPV_W'(win[SPAN][2]);
      SRC_GX:    v = OPV_W'(gdiff[0]);
      SRC_GY:    v = OPV_W'(gdiff[1]);
      SRC_GZ:    v = OPV_W'(gdiff[2]);
      SRC_HX:    v = OPV_W'(hdiff[0]);
      SRC_HY:    v = OPV_W'(hdiff[1]);
      SRC_HZ:    v = OPV_W'(hdiff[2]);
      SRC_DX:    v = OPV_W'(dreg[0]);
      SRC_DY:    v = OPV_W'(dreg[1]);
      SRC_DZ:    v = OPV_W'(dreg[2]);
      SRC_N1LO:  v = OPV_W'(n1[CHUNK-1:0]);
      SRC_N1HI:  v = OPV_W'(n1[2*CHUNK-1:CHUNK]);
      SRC_N2LO:  v = OPV_W'(n2[CHUNK-1:0]);
      SRC_N2HI:  v = OPV_W'(n2[2*CHUNK-1:CHUNK]);
      SRC_DOTLO: v = OPV_W'(dot[CHUNK-1:0]);
      SRC_DOTHI: v = OPV_W'(dot[2*CHUNK-1:CHUNK]);
      SRC_P0:    v = OPV_W'(pp[CHUNK-1:0]);
      SRC_P1:    v = OPV_W'(pp[2*CHUNK-1:CHUNK]);
      SRC_P2:    v = OPV_W'(pp[3*CHUNK-1:2*CHUNK]);
      SRC_P3:    v = OPV_W'(pp[4*CHUNK-1:3*CHUNK]);
      SRC_COS:   v = OPV_W'(cos_lim);
      SRC_PAR:   v = OPV_W'(par_ratio);
      default:   v = '0;
    endcase
    return v;
  endfunction

  // MAC pipe: operand regs, product reg, accumulate
  uop_t                    u;
  logic signed [OPV_W-1:0] va, vb;
  logic                    s1_valid, s2_valid;
  logic [MAG_W-1:0]        s1_ma, s1_mb;
  logic                    s1_neg, s2_neg;
  sh_t                     s1_sh, s2_sh;
  logic                    s1_first, s2_first;
  dst_t                    s1_dst, s2_dst;
  logic [PROD_W-1:0]       s2_prod;
  logic [ACC_W-1:0]        acc, shifted, term, sum;

  assign u  = uop_at(cmd.mac_step);
  assign va = src_val(u.a);
  assign vb = src_val(u.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_ma    <= MAG_W'(va[OPV_W-1] ? -va : va);
    s1_mb    <= MAG_W'(vb[OPV_W-1] ? -vb : vb);
    s1_neg   <= va[OPV_W-1] ^ vb[OPV_W-1];
    s1_sh    <= u.sh;
    s1_first <= u.first;
    s1_dst   <= u.dst;
    s2_prod  <= s1_ma * s1_mb;
    s2_neg   <= s1_neg;
    s2_sh    <= s1_sh;
    s2_first <= s1_first;
    s2_dst   <= s1_dst;
  end

  always_comb begin
    case (s2_sh)
      SH_0:    shifted = ACC_W'(s2_prod);
      SH_19:   shifted = ACC_W'(s2_prod) << CHUNK;
      SH_38:   shifted = ACC_W'(s2_prod) << (2 * CHUNK);
      SH_57:   shifted = ACC_W'(s2_prod) << (3 * CHUNK);
      default: shifted = ACC_W'(s2_prod);
    endcase
    // negate as invert plus carry in
    term = s2_neg ? ~shifted : shifted;
    sum  = (s2_first ? '0 : acc) + term + ACC_W'(s2_neg);
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= sum;
      case (s2_dst)
        DST_N1:   n1   <= sum[NORM_W-1:0];
        DST_N2:   n2   <= sum[NORM_W-1:0];
        DST_GAP:  gap  <= sum[GAP_W-1:0];
        DST_GAP2: gap2 <= sum[GAP_W-1:0];
        DST_DOT:  dot  <= sum[DOT_W-1:0];
        DST_CURV: curv <= (|sum[ACC_W-1:CURV_W]) ? '1 : sum[CURV_W-1:0];
        DST_LIM:  lim  <= sum[LIM_W-1:0];
        DST_PROD: pp   <= sum[PP_W-1:0];
        DST_DSQ:  dsq  <= sum[PP_W-1:0];
        DST_PCOS: pcos <= sum[PCOS_W-1:0];
        default:  ;
      endcase
    end
  end

  // occlusion and parallel-surface decisions
  always_comb begin
    occl  = (gap > GAP_W'(gap_lim)) && !dot[DOT_W-1] && (dot != '0) &&
            ({1'b0, dsq, 16'h0} > pcos);
    par   = ({gap, 16'h0} > (GAP_W+16)'(lim)) && ({gap2, 16'h0} > (GAP_W+16)'(lim));
    n1_gt = n1 > n2;
    for (int a = 0; a < WIN; a++) begin
      mark_set[a] = (occl && n1_gt && a >= SPAN + 1) ||
                    (occl && !n1_gt && a <= SPAN) ||
                    (par && a == SPAN + 1);
    end
  end

  // output register
  logic              res_valid;
  logic [CURV_W-1:0] res_curv;
  logic              res_cval, res_excl, res_last;
  logic              cval;

  assign out_space = !res_valid || results.ready;
  assign load      = cmd.emit_active && out_space;
  assign clear     = load && cmd.emit_last;
  assign cval      = (cmd.emit_age >= AGE_W'(SPAN)) &&
                     (cnt >= CNT_W'(cmd.emit_age) + CNT_W'(SPAN + 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_curv <= cval ? cdel[cmd.emit_age] : '0;
      res_cval <= cval;
      res_excl <= marks[cmd.emit_age];
      res_last <= cmd.emit_last;
    end
  end

  assign results.valid           = res_valid;
  assign results.curvature       = res_curv;
  assign results.curvature_valid = res_cval;
  assign results.excluded        = res_excl;
  assign results.last_result     = res_last;

  assign stat.end_item   = end_item;
  assign stat.cnt_ge_win = cnt >= CNT_W'(WIN);
  assign stat.flush_n    = (cnt < CNT_W'(WIN)) ? NUM_W'(cnt) : NUM_W'(WIN);
  assign stat.out_space  = out_space;

endmodule

// ===== sv/lidar_curvature_and_reject_marker_unit.sv =====
// The block takes no new point until it is through with the last one. Each point runs 32
// products through one shared 24x24 multiply-accumulate pipe, and an end-of-cloud point
// also releases its further flushed results before the next point is taken.
// Reset (synchronous rst): point count and marks cleared, registers back to defaults.
`include "assert_macros.svh"

module lidar_curvature_and_reject_marker_unit import lcrm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lcrm_point_if.sink    points,
  lcrm_result_if.source results,
  lcrm_cfg_if.sink      cfg
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  in_fire;

  assign points.ready = in_ready;
  assign in_fire      = points.valid && in_ready;

  lcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lcrm_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .cmd     (cmd),
    .stat    (stat),
    .points  (points),
    .cfg     (cfg),
    .results (results)
  );

  `ASSERT_IMPLIES(a_take_idle, clk, rst, in_fire, !cmd.mac_valid && !cmd.emit_active, "item taken while busy")
  `ASSERT_NEXT(a_mac_start, clk, rst, in_fire, cmd.mac_valid && (cmd.mac_step == '0), "MAC program did not start")
  `ASSERT_NEXT(a_flush_clear, clk, rst, cmd.emit_active && stat.out_space && cmd.emit_last, stat.flush_n == '0, "cloud state not cleared after flush")

endmodule

// ===== tb/lidar_curvature_and_reject_marker_unit_tb.sv =====
module lidar_curvature_and_reject_marker_unit_tb;
  import lcrm_pkg::*;

  typedef struct packed {
    logic [CURV_W-1:0] curvature;
    logic              curvature_valid;
    logic              excluded;
    logic              last_result;
  } marker_t;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lcrm_point_if  pt_ch ();
  lcrm_result_if res_ch ();
  lcrm_cfg_if    cfg_ch ();

  lidar_curvature_and_reject_marker_unit dut (
    .clk(clk), .rst(rst), .points(pt_ch.sink), .results(res_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint          win_pt[WIN][3];
  logic [CURV_W-1:0] win_curv[WIN];
  bit              win_mark[WIN];
  int unsigned     pt_count;
  logic [31:0]     gap_lim;
  logic [16:0]     cos_lim;
  logic [15:0]     par_ratio;

  marker_t pending_q[$];
  int      errors = 0;
  int      idle_mode = 0; // 0 none, 1 sender, 2 receiver, 3 both
  longint  quiet_cycles = 0;

  // 86 percent idling for a single side, 34 percent when both idle
  function automatic bit hit_idle();
    return $urandom_range(99) < ((idle_mode == 3) ? 34 : 86);
  endfunction

  function automatic longint mag2(longint a, longint b, longint c);
    return a * a + b * b + c * c;
  endfunction

  function automatic bit is_parallel(int i, int n);
    longint dot;
    logic [127:0] lhs, rhs;
    dot = win_pt[i][0] * win_pt[n][0] + win_pt[i][1] * win_pt[n][1]
        + win_pt[i][2] * win_pt[n][2];
    if (dot <= 0) return 1'b0;
    lhs = (128'(dot) * 128'(dot)) << 16;
    rhs = 128'(mag2(win_pt[i][0], win_pt[i][1], win_pt[i][2]))
        * 128'(mag2(win_pt[n][0], win_pt[n][1], win_pt[n][2])) * 128'(cos_lim);
    return lhs > rhs;
  endfunction

  function automatic void clear_cloud();
    for (int a = 0; a < WIN; a++) begin
      win_pt[a] = '{0, 0, 0};
      win_curv[a] = '0;
      win_mark[a] = 1'b0;
    end
    pt_count = 0;
  endfunction

  function automatic void push_marker(int age, bit last);
    marker_t m;
    bit ok;
    ok = age >= SPAN && pt_count >= age + SPAN + 1;
    m.curvature = ok ? win_curv[age] : '0;
    m.curvature_valid = ok;
    m.excluded = win_mark[age];
    m.last_result = last;
    pending_q = {pending_q, m};
  endfunction

  function automatic void predict_point(logic signed [COORD_W-1:0] x, y, z, bit eoc);
    longint d, gap, gap2, ni, nn;
    logic [127:0] acc, lim;
    int n;
    for (int a = WIN - 1; a > 0; a--) begin
      win_pt[a] = win_pt[a-1];
      win_curv[a] = win_curv[a-1];
      win_mark[a] = win_mark[a-1];
    end
    win_pt[0] = '{longint'(x), longint'(y), longint'(z)};
    win_curv[0] = '0;
    win_mark[0] = 1'b0;
    if (pt_count < 131071) pt_count++;
    if (pt_count >= 2 * SPAN + 1) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        d = -longint'(2 * SPAN) * win_pt[SPAN][k];
        for (int a = 0; a <= 2 * SPAN; a++) if (a != SPAN) d += win_pt[a][k];
        acc += 128'(d * d);
      end
      win_curv[SPAN] = (acc > {CURV_W{1'b1}}) ? {CURV_W{1'b1}} : acc[CURV_W-1:0];
    end
    if (pt_count >= 2 * SPAN + 2) begin
      gap = mag2(win_pt[SPAN+1][0] - win_pt[SPAN][0], win_pt[SPAN+1][1] - win_pt[SPAN][1],
                 win_pt[SPAN+1][2] - win_pt[SPAN][2]);
      gap2 = mag2(win_pt[SPAN+1][0] - win_pt[SPAN+2][0],
                  win_pt[SPAN+1][1] - win_pt[SPAN+2][1],
                  win_pt[SPAN+1][2] - win_pt[SPAN+2][2]);
      ni = mag2(win_pt[SPAN+1][0], win_pt[SPAN+1][1], win_pt[SPAN+1][2]);
      nn = mag2(win_pt[SPAN][0], win_pt[SPAN][1], win_pt[SPAN][2]);
      lim = 128'(par_ratio) * 128'(ni);
      if (gap > longint'(gap_lim) && is_parallel(SPAN + 1, SPAN)) begin
        if (ni > nn) for (int a = SPAN + 1; a <= 2 * SPAN + 1; a++) win_mark[a] = 1'b1;
        else for (int a = 0; a <= SPAN; a++) win_mark[a] = 1'b1;
      end
      if ((128'(gap) << 16) > lim && (128'(gap2) << 16) > lim) win_mark[SPAN+1] = 1'b1;
    end
    if (!eoc) begin
      if (pt_count >= WIN) push_marker(WIN - 1, 1'b0);
    end else begin
      n = pt_count < WIN ? pt_count : WIN;
      for (int k = 0; k < n; k++) push_marker(n - 1 - k, k == n - 1);
      clear_cloud();
    end
  endfunction

  // valid stays up after an accepted item; the block drops ready while it works
  task automatic send_point(logic signed [COORD_W-1:0] x, y, z, bit eoc);
    if (idle_mode[0] && hit_idle()) begin
      pt_ch.valid <= 1'b0;
      @(posedge clk);
      while (hit_idle()) @(posedge clk);
    end
    pt_ch.valid <= 1'b1;
    pt_ch.x_mm <= x;
    pt_ch.y_mm <= y;
    pt_ch.z_mm <= z;
    pt_ch.end_of_cloud <= eoc;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    predict_point(x, y, z, eoc);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_GAP_SQ:    gap_lim = val;
      REG_COS_SQ:    cos_lim = val[16:0];
      REG_PAR_RATIO: par_ratio = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    pt_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    marker_t exp_m;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_m = pending_q.pop_front();
          if (res_ch.curvature !== exp_m.curvature) begin
            $error("curvature exp %0d got %0d", exp_m.curvature, res_ch.curvature);
            errors++;
          end
          if (res_ch.curvature_valid !== exp_m.curvature_valid) begin
            $error("curvature_valid exp %0d got %0d", exp_m.curvature_valid,
                   res_ch.curvature_valid);
            errors++;
          end
          if (res_ch.excluded !== exp_m.excluded) begin
            $error("excluded exp %0d got %0d", exp_m.excluded, res_ch.excluded);
            errors++;
          end
          if (res_ch.last_result !== exp_m.last_result) begin
            $error("last_result exp %0d got %0d", exp_m.last_result, res_ch.last_result);
            errors++;
          end
        end
      end
      res_ch.ready <= !(idle_mode[1] && hit_idle());
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  // smooth surface near a base point, with an occasional jump, or random points when wild
  task automatic send_cloud(int len, int jump_at, bit wild);
    int bx, by, bz, stepv;
    bx = $urandom_range(20000, 1000);
    by = $urandom_range(20000, 1000);
    bz = $urandom_range(2000, 0);
    stepv = $urandom_range(300, 1);
    for (int j = 0; j < len; j++) begin
      if (wild) send_point(rand_coord(), rand_coord(), rand_coord(), j == len - 1);
      else if (j >= jump_at)
        send_point(COORD_W'(2 * bx + j * stepv), COORD_W'(2 * by + j * stepv),
                   COORD_W'(2 * bz), j == len - 1);
      else send_point(COORD_W'(bx + j * stepv), COORD_W'(by + j * stepv / 2),
                      COORD_W'(bz + $urandom_range(40)), j == len - 1);
    end
  endtask

  task automatic test_extremes();
    send_point(19'sh3FFFF, 19'sh3FFFF, 19'sh3FFFF, 1'b0);
    send_point(-19'sh40000, -19'sh40000, -19'sh40000, 1'b0);
    send_point('0, '0, '0, 1'b0);
    for (int j = 0; j < 10; j++)
      send_point(j[0] ? 19'sh3FFFF : -19'sh40000, j[1] ? 19'sh3FFFF : -19'sh40000,
                 j[2] ? -19'sh40000 : 19'sh3FFFF, 1'b0);
    send_point(-19'sh40000, 19'sh3FFFF, '0, 1'b1);
    wait_drained();
  endtask

  task automatic test_short_and_occlusion();
    send_point(COORD_W'(100), COORD_W'(200), COORD_W'(300), 1'b1);
    send_cloud(4, 99, 1'b0);
    // a near-then-far edge across a gap
    send_cloud(14, 7, 1'b0);
    wait_drained();
  endtask

  task automatic test_registers();
    logic [31:0] gaps[3] = '{32'd0, 32'hFFFFFFFF, 32'd2000};
    logic [31:0] coss[3] = '{32'd0, 32'd65536, 32'd64883};
    logic [31:0] pars[3] = '{32'd0, 32'd65535, 32'd13};
    for (int s = 0; s < 3; s++) begin
      write_reg(REG_GAP_SQ, gaps[s]);
      write_reg(REG_COS_SQ, coss[s]);
      write_reg(REG_PAR_RATIO, pars[s]);
      send_cloud(12, 6, 1'b0);
      wait_drained();
    end
  endtask

  task automatic test_random();
    int sent;
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      write_reg(REG_GAP_SQ, $urandom_range(3) == 0 ? $urandom : $urandom_range(500000));
      write_reg(REG_COS_SQ, $urandom_range(65536, 60000));
      write_reg(REG_PAR_RATIO, $urandom_range(200));
      sent = 0;
      while (sent < 10) begin
        int len;
        len = $urandom_range(4) == 0 ? $urandom_range(11, 1) : $urandom_range(14, 12);
        send_cloud(len, $urandom_range(len), $urandom_range(4) == 0);
        sent += len;
      end
      wait_drained();
    end
    idle_mode = 0;
  endtask

  initial begin
    pt_ch.valid = 1'b0;
    pt_ch.x_mm = '0;
    pt_ch.y_mm = '0;
    pt_ch.z_mm = '0;
    pt_ch.end_of_cloud = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_GAP_SQ;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    clear_cloud();
    gap_lim = GAP_RST;
    cos_lim = COS_RST;
    par_ratio = PAR_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_short_and_occlusion();
    test_registers();
    test_random();
    wait_drained();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
